// ===== rtl/crc8pd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package crc8pd_pkg;

  // Frame geometry.
  localparam int PAYLOAD_BYTES = 48;
  localparam int POS_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int ADDR_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  // CRC-8 constants and header reset value.
  localparam logic [7:0] CRC_POLY     = 8'h07;
  localparam logic [7:0] CRC_INIT     = 8'h00;
  localparam logic [7:0] HEADER_RESET = 8'hAA;

  // Controller states.
  typedef enum logic [2:0] {
    ST_HUNT,
    ST_PAYLOAD,
    ST_CRC,
    ST_ECHO_HDR,
    ST_ECHO_RD,
    ST_ECHO_LD,
    ST_ECHO_CRC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic pos_clr;
    logic pos_inc;
    logic crc_clr;
    logic crc_fold;
    logic mem_wr;
    logic mem_rd;
    logic load_hdr;
    logic load_data;
    logic load_crc;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr_match;
    logic crc_match;
    logic pos_last;
    logic out_free;
  } status_t;

  // Fold one byte into the CRC, MSB first.
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/crc8_packet_deframer.sv =====
// Header-synchronized frame receiver with CRC-8 check (poly 0x07, MSB first, init 0, no
// final xor). While hunting, bytes other than the header value are dropped; a header byte
// opens a frame of PAYLOAD_BYTES payload bytes followed by one CRC byte. A frame streams in
// at one byte per clock. On a CRC match the frame is echoed as PAYLOAD_BYTES + 2 result
// transactions (header, payload, CRC with out_frame_last set). While the echo runs, in_ready
// stays low; each payload byte after the first needs an ST_ECHO_RD state before its
// ST_ECHO_LD state because the payload memory read is registered, and output stalls
// lengthen the echo. A mismatched frame is dropped silently. The header value register
// resets to 0xAA and should only be written while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module crc8_packet_deframer
  import crc8pd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_header_value,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_frame_last
);

  cmd_t    cmd;
  status_t status;

  // Frame controller.
  crc8pd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Payload store, CRC and output register.
  crc8pd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_header_value (cfg_header_value),
    .in_byte          (in_byte),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_frame_last   (out_frame_last)
  );

endmodule
`default_nettype wire

// ===== rtl/crc8pd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crc8pd_ctrl
  import crc8pd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_HUNT: begin
        in_ready = 1'b1;
        if (in_valid && status.hdr_match) begin
          cmd.pos_clr = 1'b1;
          cmd.crc_clr = 1'b1;
          state_nxt   = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.mem_wr   = 1'b1;
          cmd.crc_fold = 1'b1;
          cmd.pos_inc  = 1'b1;
          if (status.pos_last) begin
            state_nxt = ST_CRC;
          end
        end
      end
      ST_CRC: begin
        // The received CRC byte closes the frame either way.
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.pos_clr = 1'b1;
          state_nxt   = status.crc_match ? ST_ECHO_HDR : ST_HUNT;
        end
      end
      ST_ECHO_HDR: begin
        cmd.mem_rd = 1'b1;
        if (status.out_free) begin
          cmd.load_hdr = 1'b1;
          state_nxt    = ST_ECHO_LD;
        end
      end
      ST_ECHO_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_ECHO_LD;
      end
      ST_ECHO_LD: begin
        if (status.out_free) begin
          cmd.load_data = 1'b1;
          cmd.pos_inc   = 1'b1;
          state_nxt     = status.pos_last ? ST_ECHO_CRC : ST_ECHO_RD;
        end
      end
      ST_ECHO_CRC: begin
        if (status.out_free) begin
          cmd.load_crc = 1'b1;
          cmd.pos_clr  = 1'b1;
          state_nxt    = ST_HUNT;
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/crc8pd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crc8pd_datapath
  import crc8pd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_header_value,
  input  wire logic [7:0] in_byte,
  input  wire cmd_t       cmd,
  output status_t         status,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_frame_last
);

  logic [7:0]       header_r;
  logic [POS_W-1:0] pos_r;
  logic [7:0]       crc_r;
  logic [7:0]       payload_mem [PAYLOAD_BYTES];
  logic [7:0]       rdata_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             out_load;

  // Header register, written by the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
    end else if (cfg_we) begin
      header_r <= cfg_header_value;
    end
  end

  // Byte position counter, shared by payload capture and echo readout.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.pos_clr) begin
      pos_r <= '0;
    end else if (cmd.pos_inc) begin
      pos_r <= pos_r + POS_W'(1);
    end
  end

  // Running CRC over the payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else if (cmd.crc_clr) begin
      crc_r <= CRC_INIT;
    end else if (cmd.crc_fold) begin
      crc_r <= crc8_fold(crc_r, in_byte);
    end
  end

  // Payload store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      payload_mem[pos_r[ADDR_W-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rdata_r <= payload_mem[pos_r[ADDR_W-1:0]];
    end
  end

  // Output register holding one result transaction.
  assign out_load = cmd.load_hdr | cmd.load_data | cmd.load_crc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_last_r <= cmd.load_crc;
      if (cmd.load_hdr) begin
        out_byte_r <= header_r;
      end else if (cmd.load_data) begin
        out_byte_r <= rdata_r;
      end else begin
        out_byte_r <= crc_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_frame_last = out_last_r;

  // Status back to the controller.
  assign status.hdr_match = (in_byte == header_r);
  assign status.crc_match = (in_byte == crc_r);
  assign status.pos_last  = (pos_r == POS_W'(PAYLOAD_BYTES - 1));
  assign status.out_free  = ~out_valid_r | out_ready;

endmodule
`default_nettype wire

// ===== rtl/crc8pd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crc8pd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_frame_last
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_frame_last))
    else $error("result changed while stalled");

  // A pending echo byte before the last one means input is held off.
  a_echo_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_last |-> !in_ready)
    else $error("input accepted in the middle of an echo");

  // After a non-final echo byte is taken, the echo is still running or its last byte waits.
  a_echo_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_frame_last |=> !in_ready || out_valid)
    else $error("echo ended without a last byte");

endmodule

bind crc8_packet_deframer crc8pd_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .out_frame_last (out_frame_last)
);
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import crc8pd_pkg::*;

  localparam int ECHO_CYCLES  = 2 * PAYLOAD_BYTES + 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 120;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } echo_t;

  typedef enum int {FR_GOOD, FR_BAD_CRC, FR_NOISE} frame_kind_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_header_value = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_frame_last;

  // Deframer state as the testbench tracks it.
  logic [7:0] hdr_shadow = HEADER_RESET;
  bit         rx_in_frame = 1'b0;
  int         rx_pos = 0;
  logic [7:0] rx_crc = CRC_INIT;
  logic [7:0] rx_payload [PAYLOAD_BYTES];
  echo_t      echo_q [$];

  // Stimulus controls.
  logic [7:0] tx_payload [PAYLOAD_BYTES];
  bit         sender_idle = 1'b1;
  bit         sink_idle = 1'b1;
  logic       sink_hold = 1'b0;
  int         stall_left = 0;

  int mismatch_count = 0;
  int frames_echoed = 0;
  int frames_dropped = 0;
  int header_writes = 0;
  int bytes_sent = 0;
  int cycle_count = 0;

  crc8_packet_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_header_value (cfg_header_value),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_frame_last   (out_frame_last)
  );

  always #4 clk = ~clk;

  // Serial CRC-8 update, one data bit per shift, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ d[i];
      r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // Advance the tracked deframer by one accepted byte and queue any echo it causes.
  task automatic track_rx_byte(input logic [7:0] b);
    if (!rx_in_frame) begin
      if (b == hdr_shadow) begin
        rx_in_frame = 1'b1;
        rx_pos = 0;
        rx_crc = CRC_INIT;
      end
    end else if (rx_pos < PAYLOAD_BYTES) begin
      rx_payload[rx_pos] = b;
      rx_crc = crc8_step(rx_crc, b);
      rx_pos++;
    end else begin
      rx_in_frame = 1'b0;
      rx_pos = 0;
      if (b == rx_crc) begin
        // The header echoed is the register value at the time of the echo.
        echo_q.push_back(echo_t'{hdr_shadow, 1'b0});
        foreach (rx_payload[k]) echo_q.push_back(echo_t'{rx_payload[k], 1'b0});
        echo_q.push_back(echo_t'{b, 1'b1});
        frames_echoed++;
      end else begin
        frames_dropped++;
      end
      rx_crc = CRC_INIT;
    end
  endtask

  // Compare one output transaction with the oldest pending echo byte.
  task automatic check_echo(input logic [7:0] got_byte, input logic got_last);
    echo_t want;
    if (echo_q.size() == 0) begin
      $display("%0t: unexpected output, expected none, got byte %02h last %0b",
               $time, got_byte, got_last);
      mismatch_count++;
    end else begin
      want = echo_q.pop_front();
      if (got_byte !== want.data) begin
        $display("%0t: out_byte expected %02h, got %02h", $time, want.data, got_byte);
        mismatch_count++;
      end
      if (got_last !== want.last) begin
        $display("%0t: out_frame_last expected %0b, got %0b", $time, want.last, got_last);
        mismatch_count++;
      end
    end
  endtask

  // Monitor: observe register writes and both channels at every edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_echo(out_byte, out_frame_last);
      if (cfg_we) hdr_shadow = cfg_header_value;
      if (in_valid && in_ready) track_rx_byte(in_byte);
    end
  end

  // Receiver: random stall after each transaction when sink_idle is set, plus an external hold.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      stall_left = sink_idle ? $urandom_range(0, 9) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_ready <= !sink_hold && (stall_left == 0);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d echo bytes outstanding", cycle_count,
               echo_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one byte, after a random gap when sender_idle is set, and return once the transaction is accepted.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Stop offering, then wait until every echo has arrived and the block has settled.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (echo_q.size() != 0);
    repeat (ECHO_CYCLES) @(posedge clk);
  endtask

  // Write the header register; returns once the monitor has seen the write.
  task automatic write_header(input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_header_value <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    header_writes++;
  endtask

  task automatic fill_random_payload();
    foreach (tx_payload[k]) tx_payload[k] = 8'($urandom_range(0, 255));
  endtask

  // Send header, tx_payload and its CRC, with one CRC bit flipped when corrupt is set.
  task automatic send_frame(input bit corrupt);
    logic [7:0] crc;
    crc = CRC_INIT;
    send_byte(hdr_shadow);
    foreach (tx_payload[k]) begin
      send_byte(tx_payload[k]);
      crc = crc8_step(crc, tx_payload[k]);
    end
    send_byte(corrupt ? crc ^ (8'h01 << $urandom_range(0, 7)) : crc);
  endtask

  // If the deframer is inside a frame, fill it out and end it with a wrong CRC.
  task automatic close_open_frame();
    logic [7:0] crc;
    logic [7:0] b;
    int         left;
    in_valid <= 1'b0;
    @(posedge clk);
    if (rx_in_frame) begin
      crc = rx_crc;
      left = PAYLOAD_BYTES - rx_pos;
      repeat (left) begin
        b = 8'($urandom_range(0, 255));
        send_byte(b);
        crc = crc8_step(crc, b);
      end
      send_byte(crc ^ 8'h80);
    end
  endtask

  // Reset header: noise is dropped, header bytes inside the payload and as the CRC are data.
  task automatic test_default_header();
    logic [7:0] c;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    fill_random_payload();
    tx_payload[0] = 8'h00;
    tx_payload[1] = 8'hFF;
    tx_payload[2] = HEADER_RESET;
    tx_payload[3] = HEADER_RESET;
    // Choose the last payload byte so that the CRC byte equals the header value.
    c = CRC_INIT;
    for (int k = 0; k < PAYLOAD_BYTES - 1; k++) c = crc8_step(c, tx_payload[k]);
    for (int x = 0; x < 256; x++) begin
      if (crc8_step(c, x[7:0]) == HEADER_RESET) tx_payload[PAYLOAD_BYTES - 1] = x[7:0];
    end
    send_frame(1'b0);
    wait_drained();
  endtask

  // A bad CRC drops the frame silently and hunting resumes with the next byte.
  task automatic test_bad_crc();
    fill_random_payload();
    send_frame(1'b1);
    fill_random_payload();
    send_frame(1'b0);
    wait_drained();
  endtask

  // Header register at both extremes.
  task automatic test_header_extremes();
    logic [7:0] v;
    for (int i = 0; i < 2; i++) begin
      v = (i == 0) ? 8'h00 : 8'hFF;
      write_header(v);
      send_byte(~v);
      fill_random_payload();
      send_frame(1'b0);
      wait_drained();
    end
  endtask

  // Header rewritten while a frame is half received: the new value is echoed.
  task automatic test_header_midframe();
    logic [7:0] crc;
    write_header(8'h5A);
    fill_random_payload();
    crc = CRC_INIT;
    send_byte(8'h5A);
    for (int k = 0; k < 20; k++) begin
      send_byte(tx_payload[k]);
      crc = crc8_step(crc, tx_payload[k]);
    end
    wait_drained();
    write_header(8'h3C);
    for (int k = 20; k < PAYLOAD_BYTES; k++) begin
      send_byte(tx_payload[k]);
      crc = crc8_step(crc, tx_payload[k]);
    end
    send_byte(crc);
    wait_drained();
  endtask

  // Long receiver hold while two frames are offered back to back.
  task automatic test_backpressure();
    sender_idle = 1'b0;
    sink_idle = 1'b0;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (400) @(posedge clk);
        sink_hold <= 1'b0;
      end
      begin
        fill_random_payload();
        send_frame(1'b0);
        fill_random_payload();
        send_frame(1'b0);
      end
    join
    wait_drained();
    sender_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  // Mostly well-formed frames with random content, some corrupted or truncated,
  // with stray bytes and header changes between frames.
  task automatic test_random();
    frame_kind_t kind;
    logic [7:0]  b;
    int          start_bytes;
    int          last_cfg;
    int          n;
    start_bytes = bytes_sent;
    last_cfg = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      case ($urandom_range(0, 3))
        0: begin sender_idle = 1'b1; sink_idle = 1'b1; end
        1: begin sender_idle = 1'b1; sink_idle = 1'b0; end
        2: begin sender_idle = 1'b0; sink_idle = 1'b1; end
        default: begin sender_idle = 1'b0; sink_idle = 1'b0; end
      endcase
      n = $urandom_range(0, 9);
      kind = (n < 7) ? FR_GOOD : ((n < 9) ? FR_BAD_CRC : FR_NOISE);
      // Stray bytes while hunting, never the header itself.
      repeat ($urandom_range(0, 2)) begin
        b = 8'($urandom_range(0, 255));
        send_byte((b == hdr_shadow) ? ~b : b);
      end
      case (kind)
        FR_GOOD, FR_BAD_CRC: begin
          fill_random_payload();
          send_frame(kind == FR_BAD_CRC);
        end
        default: begin
          // Header followed by a random-length run, short or overlong.
          send_byte(hdr_shadow);
          repeat ($urandom_range(1, 60)) send_byte(8'($urandom_range(0, 255)));
          close_open_frame();
        end
      endcase
      if (bytes_sent - last_cfg > 60) begin
        wait_drained();
        write_header(8'($urandom_range(0, 255)));
        last_cfg = bytes_sent;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_default_header();
    test_bad_crc();
    test_header_extremes();
    test_header_midframe();
    test_backpressure();
    test_random();
    $display("Run: %0d bytes sent across %0d header settings, including a mid-frame change.",
             bytes_sent, header_writes + 1);
    $display("Frames: %0d echoed, %0d dropped on CRC mismatch, with a long output stall.",
             frames_echoed, frames_dropped);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/crc8pd_pkg.sv
rtl/crc8pd_ctrl.sv
rtl/crc8pd_datapath.sv
rtl/crc8_packet_deframer.sv
rtl/crc8pd_checker.sv
dv/testbench.sv
